@@ src/tskl_pkg.sv @@
package tskl_pkg;

  localparam int DEPTH  = 64;  // power of two, the ring addressing wraps by truncation
  localparam int TIME_W = 48;
  localparam int KEY_W  = 64;
  localparam int DEV_W  = 24;
  localparam int OFS_W  = 49;
  localparam int CAP_W  = 7;
  localparam int STAT_W = 2;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int ENT_W  = TIME_W + KEY_W;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_GAP   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EVICT = 2'd3;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CMP, S_LRES, S_INS, S_SRD, S_SWR, S_WRN, S_TRIM, S_FIN
  } state_t;

endpackage

@@ src/tskl_in_if.sv @@
interface tskl_in_if import tskl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [TIME_W-1:0] timestamp;
  logic [KEY_W-1:0]  key_value;
  logic [DEV_W-1:0]  max_deviation;

  modport source (output valid, cmd, timestamp, key_value, max_deviation, input ready);
  modport sink   (input valid, cmd, timestamp, key_value, max_deviation, output ready);
endinterface

@@ src/tskl_out_if.sv @@
interface tskl_out_if import tskl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [TIME_W-1:0]       found_time;
  logic [KEY_W-1:0]        found_key;
  logic signed [OFS_W-1:0] time_offset;
  logic [STAT_W-1:0]       status;

  modport source (output valid, found_time, found_key, time_offset, status, input ready);
  modport sink   (input valid, found_time, found_key, time_offset, status, output ready);
endinterface

@@ src/timestamp_key_nearest_lookup_top.sv @@
// a lookup reads the entries in time order up to the first later one or the last, then picks
// the nearer; an insert scans to its slot, then moves each later entry up, or on a held time
// only rewrites the key; one request at a time; the walk over the single entry ram (one read,
// one write port) sets rate; the result register frees the output side, a new request is
// taken once the walk is done and its result has moved into the output register
// reset (rst_n low, synchronous) empties the table and sets capacity to 64, no clearing pass
module timestamp_key_nearest_lookup_top import tskl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tskl_in_if.sink           in_req,
  tskl_out_if.source        out_rsp,
  input  logic              cfg_we,
  input  logic [CAP_W-1:0]  cfg_wdata
);
  state_t state_r, state_nxt;

  logic              cmd_r, cmd_nxt;
  logic [TIME_W-1:0] t_r, t_nxt;
  logic [KEY_W-1:0]  k_r, k_nxt;
  logic [DEV_W-1:0]  dev_r, dev_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic              eq_r, eq_nxt;
  logic              full_r, full_nxt;
  logic              evict_r, evict_nxt;
  logic              upz_r, upz_nxt;
  logic              upend_r, upend_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic [ENT_W-1:0]  prev_r, prev_nxt;
  logic [ENT_W-1:0]  cur_r, cur_nxt;

  logic [TIME_W-1:0]       res_time_r, res_time_nxt;
  logic [KEY_W-1:0]        res_key_r, res_key_nxt;
  logic signed [OFS_W-1:0] res_ofs_r, res_ofs_nxt;
  logic [STAT_W-1:0]       res_st_r, res_st_nxt;

  logic                    out_v_r, out_v_nxt;
  logic [TIME_W-1:0]       out_time_r;
  logic [KEY_W-1:0]        out_key_r;
  logic signed [OFS_W-1:0] out_ofs_r;
  logic [STAT_W-1:0]       out_st_r;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;
  logic [TIME_W-1:0] rd_time;

  logic [CW-1:0]     cap_eff;
  logic              idx_last;
  logic              accept;
  logic              out_load;
  logic [TIME_W-1:0] prev_time, cur_time, dl, du, gap;
  logic              pick_prev;
  logic [ENT_W-1:0]  pick;

  tskl_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_time   = ram_rdata[ENT_W-1 -: TIME_W];
  assign prev_time = prev_r[ENT_W-1 -: TIME_W];
  assign cur_time  = cur_r[ENT_W-1 -: TIME_W];
  assign accept    = in_req.valid && in_req.ready;
  assign idx_last  = ({{(CW-AW){1'b0}}, idx_r} + CW'(1)) == cnt_r;
  assign out_load  = (state_r == S_FIN) && (!out_v_r || out_rsp.ready);

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CW'(1);
    end else if (int'(cap_r) > DEPTH) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cap_r);
    end
  end

  // nearest of the two neighbors, ties go to the later one
  always_comb begin
    dl = t_r - prev_time;
    du = cur_time - t_r;
    if (upz_r) begin
      pick_prev = 1'b0;
    end else if (upend_r) begin
      pick_prev = 1'b1;
    end else begin
      pick_prev = dl < du;
    end
    pick = pick_prev ? prev_r : cur_r;
    gap  = pick_prev ? dl : du;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req.cmd == CMD_LOOKUP && cnt_r == '0) begin
            state_nxt = S_FIN;
          end else if (cnt_r == '0) begin
            state_nxt = S_INS;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        if (cmd_r == CMD_LOOKUP) begin
          state_nxt = (rd_time > t_r || idx_last) ? S_LRES : S_RD;
        end else begin
          state_nxt = (rd_time >= t_r || idx_last) ? S_INS : S_RD;
        end
      end
      S_LRES: state_nxt = S_FIN;
      S_INS: begin
        if (eq_r) begin
          state_nxt = S_WRN;
        end else if (cnt_r == CW'(DEPTH) && pos_r == '0) begin
          state_nxt = S_FIN;
        end else if (pos_r == cnt_r) begin
          state_nxt = S_WRN;
        end else begin
          state_nxt = S_SRD;
        end
      end
      S_SRD: state_nxt = S_SWR;
      S_SWR: state_nxt = ({{(CW-AW){1'b0}}, idx_r} == pos_r) ? S_WRN : S_SRD;
      S_WRN: state_nxt = S_TRIM;
      S_TRIM: state_nxt = S_FIN;
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ram control and handshake
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = {t_r, k_r};
    ram_re    = 1'b0;
    ram_raddr = base_r + idx_r;
    in_req.ready = 1'b0;
    unique case (state_r)
      S_IDLE: in_req.ready = 1'b1;
      S_RD, S_SRD: ram_re = 1'b1;
      S_SWR: begin
        ram_we    = 1'b1;
        ram_waddr = base_r + idx_r + AW'(1);
        ram_wdata = ram_rdata;
      end
      S_WRN: begin
        ram_we    = 1'b1;
        ram_waddr = base_r + pos_r[AW-1:0];
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    cmd_nxt   = cmd_r;
    t_nxt     = t_r;
    k_nxt     = k_r;
    dev_nxt   = dev_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    eq_nxt    = eq_r;
    full_nxt  = full_r;
    evict_nxt = evict_r;
    upz_nxt   = upz_r;
    upend_nxt = upend_r;
    cnt_nxt   = cnt_r;
    base_nxt  = base_r;
    prev_nxt  = prev_r;
    cur_nxt   = cur_r;
    res_time_nxt = res_time_r;
    res_key_nxt  = res_key_r;
    res_ofs_nxt  = res_ofs_r;
    res_st_nxt   = res_st_r;
    case (state_r)
      S_IDLE: begin
        cmd_nxt   = in_req.cmd;
        t_nxt     = in_req.timestamp;
        k_nxt     = in_req.key_value;
        dev_nxt   = in_req.max_deviation;
        idx_nxt   = '0;
        pos_nxt   = '0;
        eq_nxt    = 1'b0;
        evict_nxt = 1'b0;
        upz_nxt   = 1'b0;
        upend_nxt = 1'b0;
        res_time_nxt = '0;
        res_key_nxt  = '0;
        res_ofs_nxt  = '0;
        res_st_nxt   = (in_req.cmd == CMD_LOOKUP) ? STAT_EMPTY : STAT_OK;
      end
      S_CMP: begin
        if (cmd_r == CMD_LOOKUP) begin
          if (rd_time > t_r) begin
            cur_nxt = ram_rdata;
            upz_nxt = (idx_r == '0);
          end else begin
            prev_nxt  = ram_rdata;
            upend_nxt = idx_last;
            idx_nxt   = idx_r + AW'(1);
          end
        end else begin
          if (rd_time >= t_r) begin
            pos_nxt = {{(CW-AW){1'b0}}, idx_r};
            eq_nxt  = (rd_time == t_r);
          end else begin
            pos_nxt = cnt_r;
            idx_nxt = idx_r + AW'(1);
          end
        end
      end
      S_LRES: begin
        res_time_nxt = pick[ENT_W-1 -: TIME_W];
        res_key_nxt  = pick[KEY_W-1:0];
        res_ofs_nxt  = OFS_W'({1'b0, pick[ENT_W-1 -: TIME_W]}) - OFS_W'({1'b0, t_r});
        res_st_nxt   = (gap > TIME_W'(dev_r)) ? STAT_GAP : STAT_OK;
      end
      S_INS: begin
        full_nxt = (cnt_r == CW'(DEPTH));
        idx_nxt  = AW'(cnt_r - CW'(1));
        // oldest pair into a full table is dropped at once
        if (!eq_r && cnt_r == CW'(DEPTH) && pos_r == '0) begin
          res_st_nxt = STAT_EVICT;
        end
      end
      S_SWR: begin
        idx_nxt = idx_r - AW'(1);
      end
      S_WRN: begin
        if (!eq_r) begin
          if (full_r) begin
            // the top entry (or the new pair, at the end) wrapped onto the oldest slot, so the ring start moves up
            base_nxt  = base_r + AW'(1);
            evict_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      S_TRIM: begin
        if (cnt_r > cap_eff) begin
          base_nxt = base_r + AW'(cnt_r - cap_eff);
          cnt_nxt  = cap_eff;
          res_st_nxt = STAT_EVICT;
        end else begin
          res_st_nxt = evict_r ? STAT_EVICT : STAT_OK;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      base_r  <= '0;
      cap_r   <= CAP_RESET;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      base_r  <= base_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    t_r     <= t_nxt;
    k_r     <= k_nxt;
    dev_r   <= dev_nxt;
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
    eq_r    <= eq_nxt;
    full_r  <= full_nxt;
    evict_r <= evict_nxt;
    upz_r   <= upz_nxt;
    upend_r <= upend_nxt;
    prev_r  <= prev_nxt;
    cur_r   <= cur_nxt;
    res_time_r <= res_time_nxt;
    res_key_r  <= res_key_nxt;
    res_ofs_r  <= res_ofs_nxt;
    res_st_r   <= res_st_nxt;
    if (out_load) begin
      out_time_r <= res_time_r;
      out_key_r  <= res_key_r;
      out_ofs_r  <= res_ofs_r;
      out_st_r   <= res_st_r;
    end
  end

  assign out_rsp.valid       = out_v_r;
  assign out_rsp.found_time  = out_time_r;
  assign out_rsp.found_key   = out_key_r;
  assign out_rsp.time_offset = out_ofs_r;
  assign out_rsp.status      = out_st_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("entry count above depth");

  a_trim_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TRIM) |=> (cnt_r <= $past(cap_eff))) else $error("trim left too many entries");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we) else $error("table written while idle");

endmodule

@@ src/tskl_ram.sv @@
module tskl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ tb/sv/tskl_tb_if.sv @@
`timescale 1ns / 1ps
// the block's own interface files are used for the channels; this file holds only the
// configuration bundle that the checker watches
interface tskl_cfg_if import tskl_pkg::*; ();
  logic             we;
  logic [CAP_W-1:0] wdata;

  modport source (output we, wdata);
  modport sink   (input we, wdata);
endinterface

@@ tb/sv/tskl_checker.sv @@
`timescale 1ns / 1ps
module tskl_checker import tskl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tskl_in_if.sink    mon_req,
  tskl_out_if.sink   mon_rsp,
  tskl_cfg_if.sink   mon_cfg,
  output int         fail_count,
  output int         pending_count
);

  typedef struct packed {
    logic [TIME_W-1:0]       found_time;
    logic [KEY_W-1:0]        found_key;
    logic signed [OFS_W-1:0] time_offset;
    logic [STAT_W-1:0]       status;
  } lookup_rsp_t;

  logic [TIME_W-1:0] tbl_time [DEPTH];
  logic [KEY_W-1:0]  tbl_key  [DEPTH];
  int                tbl_count;
  logic [CAP_W-1:0]  cap_reg;
  lookup_rsp_t       rsp_queue [$];

  function automatic int eff_cap();
    int c;
    c = cap_reg;
    if (c == 0) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic bit trim_table();
    int c, drop;
    c = eff_cap();
    if (tbl_count <= c) return 0;
    drop = tbl_count - c;
    for (int i = 0; i < c; i++) begin
      tbl_time[i] = tbl_time[i + drop];
      tbl_key[i]  = tbl_key[i + drop];
    end
    tbl_count = c;
    return 1;
  endfunction

  function automatic logic [STAT_W-1:0] insert_pair(logic [TIME_W-1:0] t, logic [KEY_W-1:0] k);
    int pos;
    pos = 0;
    while (pos < tbl_count && tbl_time[pos] < t) pos++;
    if (pos < tbl_count && tbl_time[pos] == t) begin
      tbl_key[pos] = k;
    end else if (tbl_count >= DEPTH) begin
      // full table: oldest goes, a new oldest pair drops straight out
      if (pos == 0) return STAT_EVICT;
      for (int i = 0; i + 1 < pos; i++) begin
        tbl_time[i] = tbl_time[i + 1];
        tbl_key[i]  = tbl_key[i + 1];
      end
      tbl_time[pos - 1] = t;
      tbl_key[pos - 1]  = k;
      void'(trim_table());
      return STAT_EVICT;
    end else begin
      for (int i = tbl_count; i > pos; i--) begin
        tbl_time[i] = tbl_time[i - 1];
        tbl_key[i]  = tbl_key[i - 1];
      end
      tbl_time[pos] = t;
      tbl_key[pos]  = k;
      tbl_count++;
    end
    return trim_table() ? STAT_EVICT : STAT_OK;
  endfunction

  function automatic lookup_rsp_t nearest_entry(logic [TIME_W-1:0] t, logic [DEV_W-1:0] dev);
    lookup_rsp_t r;
    int up, sel;
    logic [TIME_W-1:0] ft, gap;
    r = '0;
    if (tbl_count == 0) begin
      r.status = STAT_EMPTY;
      return r;
    end
    up = 0;
    while (up < tbl_count && tbl_time[up] <= t) up++;
    if (up == 0) sel = 0;
    else if (up == tbl_count) sel = tbl_count - 1;
    else sel = ((t - tbl_time[up - 1]) < (tbl_time[up] - t)) ? up - 1 : up;
    ft = tbl_time[sel];
    gap = (ft >= t) ? ft - t : t - ft;
    r.found_time  = ft;
    r.found_key   = tbl_key[sel];
    r.time_offset = {1'b0, ft} - {1'b0, t};
    r.status      = (gap > {24'd0, dev}) ? STAT_GAP : STAT_OK;
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_rsp_t exp_rsp, got;
    if (!rst_n) begin
      tbl_count     <= 0;
      cap_reg       <= CAP_RESET;
      fail_count    <= 0;
      pending_count <= 0;
      rsp_queue.delete();
    end else begin
      if (mon_cfg.we) cap_reg = mon_cfg.wdata;
      if (mon_rsp.valid && mon_rsp.ready) begin
        got = '{mon_rsp.found_time, mon_rsp.found_key, mon_rsp.time_offset, mon_rsp.status};
        if (rsp_queue.size() == 0) begin
          $error("unexpected response");
          fail_count = fail_count + 1;
        end else begin
          exp_rsp = rsp_queue.pop_front();
          if (got.found_time !== exp_rsp.found_time) begin
            $error("found_time exp %h got %h", exp_rsp.found_time, got.found_time);
            fail_count = fail_count + 1;
          end
          if (got.found_key !== exp_rsp.found_key) begin
            $error("found_key exp %h got %h", exp_rsp.found_key, got.found_key);
            fail_count = fail_count + 1;
          end
          if (got.time_offset !== exp_rsp.time_offset) begin
            $error("time_offset exp %h got %h", exp_rsp.time_offset, got.time_offset);
            fail_count = fail_count + 1;
          end
          if (got.status !== exp_rsp.status) begin
            $error("status exp %0d got %0d", exp_rsp.status, got.status);
            fail_count = fail_count + 1;
          end
        end
      end
      if (mon_req.valid && mon_req.ready) begin
        if (mon_req.cmd == CMD_INSERT) begin
          exp_rsp = '0;
          exp_rsp.status = insert_pair(mon_req.timestamp, mon_req.key_value);
        end else begin
          exp_rsp = nearest_entry(mon_req.timestamp, mon_req.max_deviation);
        end
        rsp_queue.push_back(exp_rsp);
      end
      pending_count = rsp_queue.size();
    end
  end

endmodule

@@ tb/sv/tb_timestamp_key_nearest_lookup_top.sv @@
`timescale 1ns / 1ps
module tb_timestamp_key_nearest_lookup_top import tskl_pkg::*; ();

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending_count;

  tskl_in_if  req_if ();
  tskl_out_if rsp_if ();
  tskl_cfg_if cfg_if ();

  always #5 clk = ~clk;

  timestamp_key_nearest_lookup_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_if),
    .out_rsp   (rsp_if),
    .cfg_we    (cfg_if.we),
    .cfg_wdata (cfg_if.wdata)
  );

  tskl_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .mon_req       (req_if),
    .mon_rsp       (rsp_if),
    .mon_cfg       (cfg_if),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  logic [TIME_W-1:0] time_base;
  logic [TIME_W-1:0] recent_time [$];

  task automatic send_req(logic cmd, logic [TIME_W-1:0] t, logic [KEY_W-1:0] k,
                          logic [DEV_W-1:0] dev);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk);
    req_if.valid         <= 1'b1;
    req_if.cmd           <= cmd;
    req_if.timestamp     <= t;
    req_if.key_value     <= k;
    req_if.max_deviation <= dev;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
    req_if.valid <= 1'b0;
    if (cmd == CMD_INSERT) begin
      recent_time.push_back(t);
      if (recent_time.size() > 32) void'(recent_time.pop_front());
    end
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] c);
    while (pending_count != 0) @(negedge clk);
    repeat (2 * 4 * DEPTH + 20) @(negedge clk);
    cfg_if.we    <= 1'b1;
    cfg_if.wdata <= c;
    @(negedge clk);
    cfg_if.we <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TIME_W-1:0] near_time();
    logic [TIME_W-1:0] t;
    if (recent_time.size() == 0) t = time_base;
    else t = recent_time[$urandom_range(0, recent_time.size() - 1)];
    case ($urandom_range(0, 3))
      0: return t;
      1: return t + TIME_W'($urandom_range(0, 600));
      2: return t - TIME_W'($urandom_range(0, 600));
      default: return time_base + TIME_W'($urandom_range(0, 40000));
    endcase
  endfunction

  // receiver stalls at random, with calm stretches
  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 4) == 0) stall = 0;
      rsp_if.ready <= 1'b0;
      repeat (stall) @(negedge clk);
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_if.valid) @(posedge clk);
    end
  end

  initial begin
    #80_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [TIME_W-1:0] t;
    logic [CAP_W-1:0]  caps [6];
    int                n;
    req_if.valid = 1'b0;
    req_if.cmd = CMD_INSERT;
    req_if.timestamp = '0;
    req_if.key_value = '0;
    req_if.max_deviation = '0;
    cfg_if.we = 1'b0;
    cfg_if.wdata = '0;
    time_base = TIME_W'({$urandom, $urandom});
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty lookup, extremes, exact hit, ties, outside span
    send_req(CMD_LOOKUP, '1, '1, '1);
    send_req(CMD_INSERT, '0, '1, '0);
    send_req(CMD_INSERT, '1, '0, '1);
    send_req(CMD_LOOKUP, '0, '0, '0);
    send_req(CMD_LOOKUP, '1, '1, '0);
    send_req(CMD_LOOKUP, 48'h7FFF_FFFF_FFFF, '0, '1);
    send_req(CMD_LOOKUP, 48'h8000_0000_0000, '0, '1);
    send_req(CMD_INSERT, 48'd1000, 64'hA5A5_5A5A_0F0F_F0F0, '0);
    send_req(CMD_INSERT, 48'd1010, 64'h1234_5678_9ABC_DEF0, '0);
    send_req(CMD_LOOKUP, 48'd1005, '0, 24'd5);
    send_req(CMD_LOOKUP, 48'd1004, '0, 24'd3);
    send_req(CMD_LOOKUP, 48'd1010, '0, '0);
    send_req(CMD_INSERT, 48'd1010, 64'h5555_AAAA_5555_AAAA, '0);
    send_req(CMD_LOOKUP, 48'd1011, '0, 24'd1);
    write_capacity(7'd3);
    send_req(CMD_LOOKUP, 48'd500, '0, '0);
    send_req(CMD_INSERT, 48'd1000, 64'd7, '0);
    send_req(CMD_INSERT, 48'd5, 64'd9, '0);
    send_req(CMD_LOOKUP, 48'd0, '0, '1);
    write_capacity(7'd0);
    send_req(CMD_INSERT, 48'd2000, 64'd11, '0);
    send_req(CMD_LOOKUP, 48'd1, '0, '0);
    write_capacity(7'd127);

    caps = '{7'd64, 7'd1, 7'd5, 7'd100, 7'd17, 7'd2};
    for (int ph = 0; ph < 6; ph++) begin
      write_capacity(ph == 5 ? caps[$urandom_range(0, 5)] : caps[ph]);
      n = (ph == 0) ? 400 : 125;
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0: t = TIME_W'({$urandom, $urandom});
          1: t = time_base + 48'd5000 * TIME_W'(i);
          default: t = near_time();
        endcase
        if ($urandom_range(0, 1))
          send_req(CMD_INSERT, t, rand_key(), DEV_W'($urandom));
        else
          send_req(CMD_LOOKUP, t, rand_key(),
                   $urandom_range(0, 3) == 0 ? DEV_W'($urandom)
                                             : DEV_W'($urandom_range(0, 700)));
      end
    end

    while (pending_count != 0) @(negedge clk);
    repeat (4 * DEPTH + 20) @(negedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
src/tskl_pkg.sv
src/tskl_in_if.sv
src/tskl_out_if.sv
src/tskl_ram.sv
src/timestamp_key_nearest_lookup_top.sv
tb/sv/tskl_tb_if.sv
tb/sv/tskl_checker.sv
tb/sv/tb_timestamp_key_nearest_lookup_top.sv
